/* hdl/iopd_pkg.sv */
// Package for the I/O page decoder: sizes, port addresses, codes and helpers.
`default_nettype none

package iopd_pkg;

	// Default sizes
	localparam int RAMDISK_BYTES_DEF   = 524288;
	localparam int ROM_CHIPS_DEF       = 5;
	localparam int VIDEO_REG_COUNT_DEF = 16;

	// Field widths
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int FETCH_W = 2;
	localparam int RADDR_W = 19;
	localparam int PTR_W   = 20;
	localparam int CHIP_W  = 3;
	localparam int PAGE_W  = 3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	// ROM fetch codes
	localparam logic [FETCH_W-1:0] FETCH_NONE  = 2'd0;
	localparam logic [FETCH_W-1:0] FETCH_BIOS  = 2'd1;
	localparam logic [FETCH_W-1:0] FETCH_PAGED = 2'd2;

	// Address map
	localparam logic [ADDR_W-1:0] BIOS_BASE    = 16'hF000;
	localparam logic [ADDR_W-1:0] WINDOW_BASE  = 16'hC000;
	localparam logic [ADDR_W-1:0] WINDOW_END   = 16'hE000;
	localparam logic [7:0]        IO_PAGE      = 8'hE6;

	localparam logic [ADDR_W-1:0] A_VID_IDX0   = 16'hE600;
	localparam logic [ADDR_W-1:0] A_VID_DAT0   = 16'hE601;
	localparam logic [ADDR_W-1:0] A_VID_IDX1   = 16'hE604;
	localparam logic [ADDR_W-1:0] A_VID_DAT1   = 16'hE605;
	localparam logic [ADDR_W-1:0] A_KBD_DATA   = 16'hE628;
	localparam logic [ADDR_W-1:0] A_SCR_MODE   = 16'hE629;
	localparam logic [ADDR_W-1:0] A_CTRL_A0    = 16'hE62A;
	localparam logic [ADDR_W-1:0] A_SYS_CTRL   = 16'hE62B;
	localparam logic [ADDR_W-1:0] A_CTRL_A1    = 16'hE62E;
	localparam logic [ADDR_W-1:0] A_FIXED0     = 16'hE632;
	localparam logic [ADDR_W-1:0] A_PRN_DATA   = 16'hE634;
	localparam logic [ADDR_W-1:0] A_PRN_B      = 16'hE635;
	localparam logic [ADDR_W-1:0] A_DISK_HI    = 16'hE680;
	localparam logic [ADDR_W-1:0] A_DISK_MID   = 16'hE681;
	localparam logic [ADDR_W-1:0] A_DISK_LO    = 16'hE682;
	localparam logic [ADDR_W-1:0] A_DISK_DATA  = 16'hE683;
	localparam logic [ADDR_W-1:0] A_FIXED1     = 16'hE6D0;
	localparam logic [ADDR_W-1:0] A_ROM_SEL    = 16'hE6F0;

	// Read-back constants
	localparam logic [DATA_W-1:0] STATUS_ONES  = 8'h37;
	localparam logic [DATA_W-1:0] BIT7         = 8'h80;
	localparam logic [DATA_W-1:0] BIT3         = 8'h08;

	// Four-bit chip number modulo the chip count (chip count 1..8).
	function automatic logic [CHIP_W-1:0] chip_mod(input logic [3:0] v, input int chips);
		logic [4:0] r;
		r = {1'b0, v};
		for (int k = 3; k >= 0; k--) begin
			if (32'(r) >= (32'(chips) << k))
				r = 5'(32'(r) - (32'(chips) << k));
		end
		return r[CHIP_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/io_page_decoder_with_ramdisk.sv */
// I/O page decoder with ROM paging, video register file and ramdisk.
`default_nettype none

// One bus read, bus write or 50 Hz tick is taken per transfer on the input
// channel and gives exactly one result on the output channel. The block
// sustains one item per clock while the result side does not stall: items
// pass an input register (_s1), where all decoding and state update happen,
// and then a result register (_s2), which drives the result channel.
// While a result waits, one more item can be taken into _s1; the input then
// stalls until the waiting result transfers. The ramdisk is a single-port
// memory of RAMDISK_BYTES bytes, read or written once per ramdisk data
// access as it leaves _s1; its registered read data is steered onto
// read_data for a ramdisk read.
// The ramdisk address is the loaded 20-bit pointer reduced modulo the ramdisk
// size by a short chain of compare-subtract steps (log2 of 2^20 / size,
// rounded up). Ramdisk bytes are not cleared at reset: reading a byte that
// was never written returns whatever the memory holds. No clearing pass is
// needed, the block takes items straight after reset.

module io_page_decoder_with_ramdisk #(
	parameter int RAMDISK_BYTES   = iopd_pkg::RAMDISK_BYTES_DEF,
	parameter int ROM_CHIPS       = iopd_pkg::ROM_CHIPS_DEF,
	parameter int VIDEO_REG_COUNT = iopd_pkg::VIDEO_REG_COUNT_DEF
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// input channel
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [iopd_pkg::OP_W-1:0]     op,
	input  wire  [iopd_pkg::ADDR_W-1:0]   address,
	input  wire  [iopd_pkg::DATA_W-1:0]   write_data,
	input  wire  [iopd_pkg::DATA_W-1:0]   kbd_data,
	input  wire  [iopd_pkg::DATA_W-1:0]   kbd_status,
	input  wire  [iopd_pkg::DATA_W-1:0]   printer_data,
	// result channel
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic                          claimed,
	output logic [iopd_pkg::DATA_W-1:0]   read_data,
	output logic [iopd_pkg::FETCH_W-1:0]  rom_fetch,
	output logic [iopd_pkg::RADDR_W-1:0]  rom_address,
	output logic                          speaker_level,
	output logic                          speaker_changed,
	output logic                          screen_mode_write,
	output logic                          printer_write,
	output logic                          caps_led
);
	import iopd_pkg::*;

	localparam int DISK_AW   = $clog2(RAMDISK_BYTES);
	localparam int VID_AW    = $clog2(VIDEO_REG_COUNT);
	// quotient of pointer / size fits in this many bits
	localparam int MOD_STEPS = $clog2(((1 << PTR_W) + RAMDISK_BYTES - 1) / RAMDISK_BYTES);

	// ---------------- handshake ----------------
	logic valid_s1, valid_s2;
	logic advance;
	logic accept;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	// ---------------- input register ----------------
	logic [OP_W-1:0]   op_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] wdata_s1, kdata_s1, kstat_s1, pdata_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			addr_s1  <= address;
			wdata_s1 <= write_data;
			kdata_s1 <= kbd_data;
			kstat_s1 <= kbd_status;
			pdata_s1 <= printer_data;
		end
	end

	// ---------------- block state ----------------
	logic               win_on_q;
	logic [CHIP_W-1:0]  chip_q;
	logic [PAGE_W-1:0]  page_q;
	logic [DATA_W-1:0]  vid_idx_q;
	logic [DATA_W-1:0]  vid_file_q [VIDEO_REG_COUNT];
	logic [PTR_W-1:0]   ptr_q;
	logic               tick_q;
	logic               spk_q;
	logic               caps_q;

	// pointer reduced modulo the ramdisk size
	logic [PTR_W-1:0]   slot_full;
	logic [DISK_AW-1:0] slot;
	logic [DISK_AW:0]   slot_inc;
	logic [PTR_W-1:0]   ptr_adv;

	always_comb begin
		slot_full = ptr_q;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (32'(slot_full) >= (32'(RAMDISK_BYTES) << k))
				slot_full = PTR_W'(32'(slot_full) - (32'(RAMDISK_BYTES) << k));
		end
		slot     = slot_full[DISK_AW-1:0];
		slot_inc = {1'b0, slot} + 1'b1;
		if (32'(slot_inc) == 32'(RAMDISK_BYTES))
			ptr_adv = '0;
		else
			ptr_adv = PTR_W'(slot_inc);
	end

	// ---------------- decode ----------------
	logic               rd, wr;
	logic [VID_AW-1:0]  vi;
	logic               r_claim;
	logic [DATA_W-1:0]  r_data;
	logic [FETCH_W-1:0] r_fetch;
	logic [RADDR_W-1:0] r_raddr;
	logic               r_disk_rd, r_disk_wr;
	logic               r_spk_chg, r_scr_w, r_prn_w;

	logic               win_on_d;
	logic [CHIP_W-1:0]  chip_d;
	logic [PAGE_W-1:0]  page_d;
	logic [DATA_W-1:0]  vid_idx_d;
	logic               vid_we;
	logic [PTR_W-1:0]   ptr_d;
	logic               tick_d, spk_d, caps_d;

	assign rd = (op_s1 == OP_READ);
	assign wr = (op_s1 == OP_WRITE);
	assign vi = vid_idx_q[VID_AW-1:0];

	always_comb begin
		r_claim   = 1'b0;
		r_data    = '0;
		r_fetch   = FETCH_NONE;
		r_raddr   = '0;
		r_disk_rd = 1'b0;
		r_disk_wr = 1'b0;
		r_spk_chg = 1'b0;
		r_scr_w   = 1'b0;
		r_prn_w   = 1'b0;
		win_on_d  = win_on_q;
		chip_d    = chip_q;
		page_d    = page_q;
		vid_idx_d = vid_idx_q;
		vid_we    = 1'b0;
		ptr_d     = ptr_q;
		tick_d    = tick_q;
		spk_d     = spk_q;
		caps_d    = caps_q;

		if (rd) begin
			if (addr_s1 >= BIOS_BASE) begin
				r_claim = 1'b1;
				r_fetch = FETCH_BIOS;
				r_raddr = RADDR_W'(addr_s1[11:0]);
			end else if (addr_s1 >= WINDOW_BASE && addr_s1 < WINDOW_END) begin
				if (win_on_q) begin
					r_claim = 1'b1;
					r_fetch = FETCH_PAGED;
					r_raddr = {chip_q, page_q, addr_s1[12:0]};
				end
			end else if (addr_s1[15:8] == IO_PAGE) begin
				r_claim = 1'b1;
				unique case (addr_s1)
					A_VID_IDX0, A_VID_IDX1: r_data = vid_idx_q;
					A_VID_DAT0, A_VID_DAT1: r_data = vid_file_q[vi];
					A_KBD_DATA:             r_data = kdata_s1;
					A_CTRL_A0, A_CTRL_A1:
						r_data = kstat_s1 | (caps_q ? 8'h00 : BIT3) | STATUS_ONES;
					A_SYS_CTRL: begin
						r_data = (tick_q ? BIT7 : 8'h00) | (spk_q ? BIT3 : 8'h00)
							| STATUS_ONES;
						tick_d = 1'b0;  // read clears the tick
					end
					A_FIXED0, A_FIXED1:     r_data = BIT7;
					A_DISK_DATA: begin
						r_disk_rd = 1'b1;
						ptr_d     = ptr_adv;
					end
					A_PRN_DATA:             r_data = pdata_s1;
					default:                r_claim = 1'b0;
				endcase
			end
		end else if (wr) begin
			unique case (addr_s1)
				A_ROM_SEL: begin
					win_on_d = wdata_s1[3];
					if (wdata_s1[3]) begin
						chip_d = chip_mod(wdata_s1[7:4], ROM_CHIPS);
						page_d = wdata_s1[2:0];
					end
				end
				A_VID_IDX0, A_VID_IDX1: vid_idx_d = wdata_s1;
				A_VID_DAT0, A_VID_DAT1: vid_we = 1'b1;
				A_SCR_MODE:             r_scr_w = 1'b1;
				A_CTRL_A0, A_CTRL_A1:   caps_d = !wdata_s1[3];
				A_SYS_CTRL: begin
					spk_d     = wdata_s1[3];
					r_spk_chg = (wdata_s1[3] != spk_q);
				end
				A_PRN_B:                r_prn_w = 1'b1;
				A_DISK_HI:              ptr_d = {wdata_s1[3:0], ptr_q[15:0]};
				A_DISK_MID:             ptr_d = {ptr_q[19:16], wdata_s1, ptr_q[7:0]};
				A_DISK_LO:              ptr_d = {ptr_q[19:8], wdata_s1};
				A_DISK_DATA: begin
					r_disk_wr = 1'b1;
					ptr_d     = ptr_adv;
				end
				default: ;
			endcase
		end else if (op_s1 == OP_TICK) begin
			tick_d = 1'b1;
		end
	end

	// state update as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_on_q  <= 1'b0;
			chip_q    <= '0;
			page_q    <= '0;
			vid_idx_q <= '0;
			for (int i = 0; i < VIDEO_REG_COUNT; i++)
				vid_file_q[i] <= '0;
			ptr_q     <= '0;
			tick_q    <= 1'b0;
			spk_q     <= 1'b0;
			caps_q    <= 1'b0;
		end else if (advance) begin
			win_on_q  <= win_on_d;
			chip_q    <= chip_d;
			page_q    <= page_d;
			vid_idx_q <= vid_idx_d;
			if (vid_we)
				vid_file_q[vi] <= wdata_s1;
			ptr_q     <= ptr_d;
			tick_q    <= tick_d;
			spk_q     <= spk_d;
			caps_q    <= caps_d;
		end
	end

	// ---------------- ramdisk ----------------
	logic [DATA_W-1:0] disk_mem [RAMDISK_BYTES];
	logic [DATA_W-1:0] disk_rd_q;

	always_ff @(posedge clk) begin
		if (advance && r_disk_wr)
			disk_mem[slot] <= wdata_s1;
		if (advance && r_disk_rd)
			disk_rd_q <= disk_mem[slot];
	end

	// ---------------- result register ----------------
	logic               claim_s2;
	logic [DATA_W-1:0]  data_s2;
	logic [FETCH_W-1:0] fetch_s2;
	logic [RADDR_W-1:0] raddr_s2;
	logic               disk_sel_s2;
	logic               spk_lvl_s2, spk_chg_s2, scr_w_s2, prn_w_s2, caps_s2;

	always_ff @(posedge clk) begin
		if (advance) begin
			claim_s2    <= r_claim;
			data_s2     <= r_data;
			fetch_s2    <= r_fetch;
			raddr_s2    <= r_raddr;
			disk_sel_s2 <= r_disk_rd;
			spk_lvl_s2  <= spk_d;
			spk_chg_s2  <= r_spk_chg;
			scr_w_s2    <= r_scr_w;
			prn_w_s2    <= r_prn_w;
			caps_s2     <= caps_d;
		end
	end

	assign claimed           = claim_s2;
	assign read_data         = disk_sel_s2 ? disk_rd_q : data_s2;
	assign rom_fetch         = fetch_s2;
	assign rom_address       = raddr_s2;
	assign speaker_level     = spk_lvl_s2;
	assign speaker_changed   = spk_chg_s2;
	assign screen_mode_write = scr_w_s2;
	assign printer_write     = prn_w_s2;
	assign caps_led          = caps_s2;

endmodule

`default_nettype wire
